// ===== rtl/cpt_pkg.sv =====
// cpt_pkg: widths, region codes and the transaction type passed from the
// classifier front end to the divide/interpolate back end.
// No dependencies.
package cpt_pkg;

    localparam int CW   = 32;           // coordinate width
    localparam int EW   = CW + 1;       // edge / offset vector width
    localparam int PW   = 2 * EW;       // one coordinate product
    localparam int DW   = PW + 2;       // dot product
    localparam int HALF = DW / 2;       // limb width for cross products
    localparam int PPW  = 2 * (HALF + 1);
    localparam int XW   = 2 * DW + 1;   // cross term
    localparam int NW   = XW + 2;       // weight numerator / denominator
    localparam int WB   = 24;           // weight fraction bits
    localparam int WW   = WB + 1;       // weight width including 1.0

    typedef enum logic [2:0] {
        REG_A  = 3'd0,
        REG_B  = 3'd1,
        REG_C  = 3'd2,
        REG_AB = 3'd3,
        REG_AC = 3'd4,
        REG_BC = 3'd5,
        REG_IN = 3'd6
    } region_t;

    typedef struct packed {
        region_t                region;
        logic signed [NW-1:0]   num1;
        logic signed [NW-1:0]   den1;
        logic signed [NW-1:0]   num2;
        logic signed [NW-1:0]   den2;
        logic [2:0][CW-1:0]     start;
        logic [2:0][EW-1:0]     e1;
        logic [2:0][EW-1:0]     e2;
    } work_t;

    function automatic logic signed [PW-1:0] emul(logic signed [EW-1:0] x,
                                                  logic signed [EW-1:0] y);
        return x * y;
    endfunction

endpackage

// ===== rtl/closest_point_on_triangle_core.sv =====
// closest_point_on_triangle_core: closest point on a triangle, Voronoi-region method.
// Accepts one transaction per cycle while neither end stalls (6 classifier stages, the queue,
// 25 divider stages, 2 output stages).
// Both ends stall independently through the QUEUE_DEPTH-entry queue.
// rst_n clears all valid state asynchronously; data registers are not reset.
// Depends on cpt_pkg, cpt_front, cpt_queue, cpt_back.
module closest_point_on_triangle_core
    import cpt_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [CW-1:0] point_x,
    input  logic signed [CW-1:0] point_y,
    input  logic signed [CW-1:0] point_z,
    input  logic signed [CW-1:0] vert_a_x,
    input  logic signed [CW-1:0] vert_a_y,
    input  logic signed [CW-1:0] vert_a_z,
    input  logic signed [CW-1:0] vert_b_x,
    input  logic signed [CW-1:0] vert_b_y,
    input  logic signed [CW-1:0] vert_b_z,
    input  logic signed [CW-1:0] vert_c_x,
    input  logic signed [CW-1:0] vert_c_y,
    input  logic signed [CW-1:0] vert_c_z,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [CW-1:0] near_x,
    output logic signed [CW-1:0] near_y,
    output logic signed [CW-1:0] near_z,
    output logic [2:0]           region
);

    logic  f_valid, f_ready, b_valid, b_ready;
    work_t f_work, b_work;

    cpt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .point_x    (point_x),
        .point_y    (point_y),
        .point_z    (point_z),
        .vert_a_x   (vert_a_x),
        .vert_a_y   (vert_a_y),
        .vert_a_z   (vert_a_z),
        .vert_b_x   (vert_b_x),
        .vert_b_y   (vert_b_y),
        .vert_b_z   (vert_b_z),
        .vert_c_x   (vert_c_x),
        .vert_c_y   (vert_c_y),
        .vert_c_z   (vert_c_z),
        .work_valid (f_valid),
        .work_ready (f_ready),
        .work       (f_work)
    );

    cpt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (f_work),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_data   (b_work)
    );

    cpt_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .work_valid (b_valid),
        .work_ready (b_ready),
        .work       (b_work),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .near_x     (near_x),
        .near_y     (near_y),
        .near_z     (near_z),
        .region     (region)
    );

endmodule

// ===== rtl/cpt_front.sv =====
// cpt_front: exact dot products, cross terms and Voronoi region decision.
// Depends on cpt_pkg.
module cpt_front
    import cpt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [CW-1:0] point_x,
    input  logic signed [CW-1:0] point_y,
    input  logic signed [CW-1:0] point_z,
    input  logic signed [CW-1:0] vert_a_x,
    input  logic signed [CW-1:0] vert_a_y,
    input  logic signed [CW-1:0] vert_a_z,
    input  logic signed [CW-1:0] vert_b_x,
    input  logic signed [CW-1:0] vert_b_y,
    input  logic signed [CW-1:0] vert_b_z,
    input  logic signed [CW-1:0] vert_c_x,
    input  logic signed [CW-1:0] vert_c_y,
    input  logic signed [CW-1:0] vert_c_z,
    output logic                 work_valid,
    input  logic                 work_ready,
    output work_t                work
);

    localparam int FS = 6;

    typedef struct packed {
        logic [2:0][CW-1:0] a;
        logic [2:0][CW-1:0] b;
        logic [2:0][CW-1:0] c;
        logic [2:0][EW-1:0] ab;
        logic [2:0][EW-1:0] ac;
        logic [2:0][EW-1:0] bc;
    } geo_t;

    logic [FS-1:0] vld_reg;
    logic          adv;

    logic signed [CW-1:0] p [3];
    logic signed [CW-1:0] a [3];
    logic signed [CW-1:0] b [3];
    logic signed [CW-1:0] c [3];

    geo_t               geo_reg [FS-1];
    geo_t               geo_next;
    logic [2:0][EW-1:0] ap_reg, bp_reg, cp_reg;
    logic [2:0][EW-1:0] ap_next, bp_next, cp_next;

    logic signed [PW-1:0]  pr_reg  [6][3];
    logic signed [PW-1:0]  pr_next [6][3];
    logic signed [DW-1:0]  d_reg   [6];
    logic signed [DW-1:0]  d_next  [6];
    logic signed [DW-1:0]  d3_reg  [6];
    logic signed [DW-1:0]  d4_reg  [6];
    logic signed [PPW-1:0] pp_reg  [6][4];
    logic signed [PPW-1:0] pp_next [6][4];
    logic signed [XW-1:0]  va_reg, vb_reg, vc_reg;
    logic signed [XW-1:0]  va_next, vb_next, vc_next;
    work_t                 work_reg, work_next;

    assign p[0] = point_x;  assign p[1] = point_y;  assign p[2] = point_z;
    assign a[0] = vert_a_x; assign a[1] = vert_a_y; assign a[2] = vert_a_z;
    assign b[0] = vert_b_x; assign b[1] = vert_b_y; assign b[2] = vert_b_z;
    assign c[0] = vert_c_x; assign c[1] = vert_c_y; assign c[2] = vert_c_z;

    assign adv        = !vld_reg[FS-1] || work_ready;
    assign in_ready   = adv;
    assign work_valid = vld_reg[FS-1];
    assign work       = work_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[FS-2:0], in_valid};
        end
    end

    // stage 0: edge and offset vectors
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            geo_next.a[i]  = a[i];
            geo_next.b[i]  = b[i];
            geo_next.c[i]  = c[i];
            geo_next.ab[i] = EW'(b[i]) - EW'(a[i]);
            geo_next.ac[i] = EW'(c[i]) - EW'(a[i]);
            geo_next.bc[i] = EW'(c[i]) - EW'(b[i]);
            ap_next[i]     = EW'(p[i]) - EW'(a[i]);
            bp_next[i]     = EW'(p[i]) - EW'(b[i]);
            cp_next[i]     = EW'(p[i]) - EW'(c[i]);
        end
    end

    // stage 1: coordinate products, d1..d6 = (ab,ac) x (ap,bp,cp)
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pr_next[0][i] = emul($signed(geo_reg[0].ab[i]), $signed(ap_reg[i]));
            pr_next[1][i] = emul($signed(geo_reg[0].ac[i]), $signed(ap_reg[i]));
            pr_next[2][i] = emul($signed(geo_reg[0].ab[i]), $signed(bp_reg[i]));
            pr_next[3][i] = emul($signed(geo_reg[0].ac[i]), $signed(bp_reg[i]));
            pr_next[4][i] = emul($signed(geo_reg[0].ab[i]), $signed(cp_reg[i]));
            pr_next[5][i] = emul($signed(geo_reg[0].ac[i]), $signed(cp_reg[i]));
        end
    end

    // stage 2: dot product sums
    always_comb
    begin
        for (int k = 0; k < 6; k++)
        begin
            d_next[k] = DW'(pr_reg[k][0]) + DW'(pr_reg[k][1]) + DW'(pr_reg[k][2]);
        end
    end

    // stage 3: limb partial products of d1*d4, d3*d2, d5*d2, d1*d6, d3*d6, d5*d4
    always_comb
    begin
        logic signed [DW-1:0]   x;
        logic signed [DW-1:0]   y;
        logic signed [HALF-1:0] xh;
        logic signed [HALF-1:0] yh;
        logic signed [HALF:0]   xl;
        logic signed [HALF:0]   yl;
        for (int k = 0; k < 6; k++)
        begin
            unique case (k)
                0:       begin x = d_reg[0]; y = d_reg[3]; end
                1:       begin x = d_reg[2]; y = d_reg[1]; end
                2:       begin x = d_reg[4]; y = d_reg[1]; end
                3:       begin x = d_reg[0]; y = d_reg[5]; end
                4:       begin x = d_reg[2]; y = d_reg[5]; end
                default: begin x = d_reg[4]; y = d_reg[3]; end
            endcase
            xh = $signed(x[DW-1:HALF]);
            yh = $signed(y[DW-1:HALF]);
            xl = $signed({1'b0, x[HALF-1:0]});
            yl = $signed({1'b0, y[HALF-1:0]});
            pp_next[k][0] = xh * yh;
            pp_next[k][1] = xh * yl;
            pp_next[k][2] = xl * yh;
            pp_next[k][3] = xl * yl;
        end
    end

    // stage 4: cross products and the three area terms
    always_comb
    begin
        logic signed [XW-1:0] xp [6];
        for (int k = 0; k < 6; k++)
        begin
            xp[k] = (XW'(pp_reg[k][0]) <<< (2 * HALF))
                  + ((XW'(pp_reg[k][1]) + XW'(pp_reg[k][2])) <<< HALF)
                  + XW'(pp_reg[k][3]);
        end
        vc_next = xp[0] - xp[1];
        vb_next = xp[2] - xp[3];
        va_next = xp[4] - xp[5];
    end

    // stage 5: region decision and weight operands
    always_comb
    begin
        logic signed [DW-1:0] d1, d2, d3, d4, d5, d6;
        logic signed [NW-1:0] e43, e56, den;
        geo_t                 g;
        g   = geo_reg[FS-2];
        d1  = d4_reg[0]; d2 = d4_reg[1]; d3 = d4_reg[2];
        d4  = d4_reg[3]; d5 = d4_reg[4]; d6 = d4_reg[5];
        e43 = NW'(d4) - NW'(d3);
        e56 = NW'(d5) - NW'(d6);
        den = NW'(va_reg) + NW'(vb_reg) + NW'(vc_reg);
        work_next        = '0;
        work_next.region = REG_A;
        work_next.start  = g.a;
        priority if (d1 <= 0 && d2 <= 0)
        begin
            work_next.region = REG_A;
        end
        else if (d3 >= 0 && d3 >= d4)
        begin
            work_next.region = REG_B;
            work_next.start  = g.b;
        end
        else if (vc_reg <= 0 && d1 >= 0 && d3 <= 0)
        begin
            work_next.region = REG_AB;
            work_next.num1   = NW'(d1);
            work_next.den1   = NW'(d1) - NW'(d3);
            work_next.e1     = g.ab;
        end
        else if (d6 >= 0 && d6 >= d5)
        begin
            work_next.region = REG_C;
            work_next.start  = g.c;
        end
        else if (vb_reg <= 0 && d2 >= 0 && d6 <= 0)
        begin
            work_next.region = REG_AC;
            work_next.num1   = NW'(d2);
            work_next.den1   = NW'(d2) - NW'(d6);
            work_next.e1     = g.ac;
        end
        else if (va_reg <= 0 && e43 >= 0 && e56 >= 0)
        begin
            work_next.region = REG_BC;
            work_next.start  = g.b;
            work_next.num1   = e43;
            work_next.den1   = e43 + e56;
            work_next.e1     = g.bc;
        end
        else if (den <= 0)
        begin
            work_next.region = REG_A;
        end
        else
        begin
            work_next.region = REG_IN;
            work_next.num1   = NW'(vb_reg);
            work_next.den1   = den;
            work_next.num2   = NW'(vc_reg);
            work_next.den2   = den;
            work_next.e1     = g.ab;
            work_next.e2     = g.ac;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            geo_reg[0] <= geo_next;
            for (int s = 1; s < FS - 1; s++)
            begin
                geo_reg[s] <= geo_reg[s-1];
            end
            ap_reg   <= ap_next;
            bp_reg   <= bp_next;
            cp_reg   <= cp_next;
            pr_reg   <= pr_next;
            d_reg    <= d_next;
            d3_reg   <= d_reg;
            d4_reg   <= d3_reg;
            pp_reg   <= pp_next;
            va_reg   <= va_next;
            vb_reg   <= vb_next;
            vc_reg   <= vc_next;
            work_reg <= work_next;
        end
    end

endmodule

// ===== rtl/cpt_queue.sv =====
// cpt_queue: small FIFO of work transactions between front and back end.
// Depends on cpt_pkg. DEPTH must be a power of two, at least 2.
module cpt_queue
    import cpt_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push_valid,
    output logic  push_ready,
    input  work_t push_data,
    output logic  pop_valid,
    input  logic  pop_ready,
    output work_t pop_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int NB = $clog2(DEPTH + 1);

    work_t         mem [DEPTH];
    logic [AW-1:0] wr_reg, rd_reg;
    logic [NB-1:0] cnt_reg;
    logic          push, pop;

    assign push_ready = cnt_reg != NB'(DEPTH);
    assign pop_valid  = cnt_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + AW'(1);
            end
            if (pop)
            begin
                rd_reg <= rd_reg + AW'(1);
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + NB'(1);
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - NB'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/cpt_back.sv =====
// cpt_back: pipelined restoring division of the weights and interpolation
// of the closest point. Depends on cpt_pkg.
module cpt_back
    import cpt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 work_valid,
    output logic                 work_ready,
    input  work_t                work,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [CW-1:0] near_x,
    output logic signed [CW-1:0] near_y,
    output logic signed [CW-1:0] near_z,
    output logic [2:0]           region
);

    localparam int BS = WB + 3;
    localparam int MW = EW + WW + 1;

    typedef struct packed {
        region_t            region;
        logic [2:0][CW-1:0] start;
        logic [2:0][EW-1:0] e1;
        logic [2:0][EW-1:0] e2;
        logic [1:0]         zero;
        logic [1:0]         one;
        logic [1:0][NW:0]   r;
        logic [1:0][NW-1:0] dn;
        logic [1:0][WB-1:0] q;
    } div_t;

    logic [BS-1:0] vld_reg;
    logic          adv;

    div_t                 dv_reg  [WB+1];
    div_t                 dv_next [WB+1];
    region_t              m_region_reg;
    logic [2:0][CW-1:0]   m_start_reg;
    logic signed [MW-1:0] m_reg  [2][3];
    logic signed [MW-1:0] m_next [2][3];
    region_t              o_region_reg;
    logic signed [CW-1:0] o_reg  [3];
    logic signed [CW-1:0] o_next [3];

    assign adv        = !vld_reg[BS-1] || out_ready;
    assign work_ready = adv;
    assign out_valid  = vld_reg[BS-1];
    assign near_x     = o_reg[0];
    assign near_y     = o_reg[1];
    assign near_z     = o_reg[2];
    assign region     = o_region_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[BS-2:0], work_valid};
        end
    end

    always_comb
    begin
        logic signed [NW-1:0] nm [2];
        logic signed [NW-1:0] dd [2];
        nm[0] = work.num1; nm[1] = work.num2;
        dd[0] = work.den1; dd[1] = work.den2;
        dv_next[0].region = work.region;
        dv_next[0].start  = work.start;
        dv_next[0].e1     = work.e1;
        dv_next[0].e2     = work.e2;
        for (int j = 0; j < 2; j++)
        begin
            dv_next[0].zero[j] = dd[j] <= 0 || nm[j] <= 0;
            dv_next[0].one[j]  = nm[j] >= dd[j];
            dv_next[0].r[j]    = (NW + 1)'(unsigned'(nm[j]));
            dv_next[0].dn[j]   = dd[j];
            dv_next[0].q[j]    = '0;
        end
    end

    for (genvar s = 1; s <= WB; s++)
    begin : g_div
        always_comb
        begin
            logic [NW:0] t;
            logic        ge;
            dv_next[s] = dv_reg[s-1];
            for (int j = 0; j < 2; j++)
            begin
                t  = {dv_reg[s-1].r[j][NW-1:0], 1'b0};
                ge = t >= {1'b0, dv_reg[s-1].dn[j]};
                dv_next[s].r[j] = ge ? t - {1'b0, dv_reg[s-1].dn[j]} : t;
                dv_next[s].q[j] = {dv_reg[s-1].q[j][WB-2:0], ge};
            end
        end
    end

    always_comb
    begin
        logic [WW-1:0] w [2];
        div_t          dv;
        dv = dv_reg[WB];
        for (int j = 0; j < 2; j++)
        begin
            priority if (dv.zero[j])
                w[j] = '0;
            else if (dv.one[j])
                w[j] = WW'(1) << WB;
            else
                w[j] = {1'b0, dv.q[j]};
        end
        for (int i = 0; i < 3; i++)
        begin
            m_next[0][i] = $signed(dv.e1[i]) * $signed({1'b0, w[0]});
            m_next[1][i] = $signed(dv.e2[i]) * $signed({1'b0, w[1]});
        end
    end

    always_comb
    begin
        logic signed [MW:0] sum;
        for (int i = 0; i < 3; i++)
        begin
            sum       = (MW + 1)'(m_reg[0][i]) + (MW + 1)'(m_reg[1][i]);
            o_next[i] = $signed(m_start_reg[i]) + $signed(sum[WB+CW-1:WB]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int s = 0; s <= WB; s++)
            begin
                dv_reg[s] <= dv_next[s];
            end
            m_region_reg <= dv_reg[WB].region;
            m_start_reg  <= dv_reg[WB].start;
            m_reg        <= m_next;
            o_region_reg <= m_region_reg;
            o_reg        <= o_next;
        end
    end

endmodule

// ===== dv/testbench.sv =====
// Self-checking bench for closest_point_on_triangle_core: directed and random
// triangle queries, an exact wide-integer closest-point predictor and random stalls.
// Depends on cpt_pkg and the RTL of closest_point_on_triangle_core.
`timescale 1ns / 100ps

module testbench;
    import cpt_pkg::*;

    localparam int  LATENCY    = 33;
    localparam int  GAP_MAX    = 18;
    localparam int  RAND_ITEMS = 1000;
    localparam longint CYCLE_LIMIT = 400000;
    localparam int  Q1         = 65536;

    typedef logic signed [255:0] wide_t;
    typedef logic [2:0][CW-1:0] vec3_t;

    typedef struct {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [CW-1:0] z;
        region_t       rgn;
    } near_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [CW-1:0] point_x = '0, point_y = '0, point_z = '0;
    logic signed [CW-1:0] vert_a_x = '0, vert_a_y = '0, vert_a_z = '0;
    logic signed [CW-1:0] vert_b_x = '0, vert_b_y = '0, vert_b_z = '0;
    logic signed [CW-1:0] vert_c_x = '0, vert_c_y = '0, vert_c_z = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [CW-1:0] near_x, near_y, near_z;
    logic [2:0] region;

    near_t  nearest_q[$];
    int     mismatches = 0;
    int     results_seen = 0;
    int     region_hits[7];
    int     rx_hold = 0;
    bit     rx_no_stall = 1'b0;
    bit     tx_no_gap = 1'b0;
    longint cycles = 0;

    closest_point_on_triangle_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .point_x(point_x), .point_y(point_y), .point_z(point_z),
        .vert_a_x(vert_a_x), .vert_a_y(vert_a_y), .vert_a_z(vert_a_z),
        .vert_b_x(vert_b_x), .vert_b_y(vert_b_y), .vert_b_z(vert_b_z),
        .vert_c_x(vert_c_x), .vert_c_y(vert_c_y), .vert_c_z(vert_c_z),
        .out_valid(out_valid), .out_ready(out_ready),
        .near_x(near_x), .near_y(near_y), .near_z(near_z), .region(region)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic wide_t dot3(wide_t x0, wide_t x1, wide_t x2,
                                   wide_t y0, wide_t y1, wide_t y2);
        return x0 * y0 + x1 * y1 + x2 * y2;
    endfunction

    // floor(num * 2^WB / den), clamped to [0, 1.0]
    function automatic wide_t frac_weight(wide_t num, wide_t den);
        if (den <= 0 || num <= 0)
            return 0;
        if (num >= den)
            return wide_t'(1) <<< WB;
        return (num <<< WB) / den;
    endfunction

    function automatic near_t predict_nearest(vec3_t p, vec3_t a, vec3_t b, vec3_t c);
        wide_t pw[3], aw[3], bw[3], cw[3];
        wide_t ab[3], ac[3], bc[3], ap[3], bp[3], cp[3];
        wide_t d1, d2, d3, d4, d5, d6, va, vb, vc, e43, e56, den, v, w, t;
        near_t r;
        for (int i = 0; i < 3; i++)
        begin
            pw[i] = $signed(p[i]);
            aw[i] = $signed(a[i]);
            bw[i] = $signed(b[i]);
            cw[i] = $signed(c[i]);
            ab[i] = bw[i] - aw[i];
            ac[i] = cw[i] - aw[i];
            bc[i] = cw[i] - bw[i];
            ap[i] = pw[i] - aw[i];
            bp[i] = pw[i] - bw[i];
            cp[i] = pw[i] - cw[i];
        end
        r.x = a[0]; r.y = a[1]; r.z = a[2]; r.rgn = REG_A;
        d1 = dot3(ab[0], ab[1], ab[2], ap[0], ap[1], ap[2]);
        d2 = dot3(ac[0], ac[1], ac[2], ap[0], ap[1], ap[2]);
        if (d1 <= 0 && d2 <= 0)
            return r;
        d3 = dot3(ab[0], ab[1], ab[2], bp[0], bp[1], bp[2]);
        d4 = dot3(ac[0], ac[1], ac[2], bp[0], bp[1], bp[2]);
        if (d3 >= 0 && d3 >= d4)
        begin
            r.x = b[0]; r.y = b[1]; r.z = b[2]; r.rgn = REG_B;
            return r;
        end
        vc = d1 * d4 - d3 * d2;
        if (vc <= 0 && d1 >= 0 && d3 <= 0)
        begin
            v = frac_weight(d1, d1 - d3);
            t = aw[0] + ((ab[0] * v) >>> WB); r.x = t[CW-1:0];
            t = aw[1] + ((ab[1] * v) >>> WB); r.y = t[CW-1:0];
            t = aw[2] + ((ab[2] * v) >>> WB); r.z = t[CW-1:0];
            r.rgn = REG_AB;
            return r;
        end
        d5 = dot3(ab[0], ab[1], ab[2], cp[0], cp[1], cp[2]);
        d6 = dot3(ac[0], ac[1], ac[2], cp[0], cp[1], cp[2]);
        if (d6 >= 0 && d6 >= d5)
        begin
            r.x = c[0]; r.y = c[1]; r.z = c[2]; r.rgn = REG_C;
            return r;
        end
        vb = d5 * d2 - d1 * d6;
        if (vb <= 0 && d2 >= 0 && d6 <= 0)
        begin
            w = frac_weight(d2, d2 - d6);
            t = aw[0] + ((ac[0] * w) >>> WB); r.x = t[CW-1:0];
            t = aw[1] + ((ac[1] * w) >>> WB); r.y = t[CW-1:0];
            t = aw[2] + ((ac[2] * w) >>> WB); r.z = t[CW-1:0];
            r.rgn = REG_AC;
            return r;
        end
        va = d3 * d6 - d5 * d4;
        e43 = d4 - d3;
        e56 = d5 - d6;
        if (va <= 0 && e43 >= 0 && e56 >= 0)
        begin
            w = frac_weight(e43, e43 + e56);
            t = bw[0] + ((bc[0] * w) >>> WB); r.x = t[CW-1:0];
            t = bw[1] + ((bc[1] * w) >>> WB); r.y = t[CW-1:0];
            t = bw[2] + ((bc[2] * w) >>> WB); r.z = t[CW-1:0];
            r.rgn = REG_BC;
            return r;
        end
        den = va + vb + vc;
        if (den <= 0)
            return r;
        v = frac_weight(vb, den);
        w = frac_weight(vc, den);
        t = aw[0] + ((ab[0] * v + ac[0] * w) >>> WB); r.x = t[CW-1:0];
        t = aw[1] + ((ab[1] * v + ac[1] * w) >>> WB); r.y = t[CW-1:0];
        t = aw[2] + ((ab[2] * v + ac[2] * w) >>> WB); r.z = t[CW-1:0];
        r.rgn = REG_IN;
        return r;
    endfunction

    // result side: per-transaction stall draw, plus long hold-off on request
    initial
    begin
        int wait_cnt;
        near_t e;
        wait_cnt = 0;
        @(posedge rst_n);
        out_ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (nearest_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %h %h %h region %0d",
                                 near_x, near_y, near_z, region);
                end
                else
                begin
                    e = nearest_q.pop_front();
                    if (region < 7)
                        region_hits[region]++;
                    if (near_x !== e.x || near_y !== e.y || near_z !== e.z
                        || region !== e.rgn)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp %h %h %h r%0d, got %h %h %h r%0d",
                                     e.x, e.y, e.z, e.rgn, near_x, near_y, near_z, region);
                    end
                end
                wait_cnt = rx_no_stall ? 0 : $urandom_range(0, GAP_MAX);
            end
            else if (wait_cnt > 0)
                wait_cnt--;
            if (rx_hold > 0)
            begin
                rx_hold--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= (wait_cnt == 0);
        end
    end

    task automatic send_query(vec3_t p, vec3_t a, vec3_t b, vec3_t c);
        int gap;
        gap = tx_no_gap ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        point_x <= p[0];  point_y <= p[1];  point_z <= p[2];
        vert_a_x <= a[0]; vert_a_y <= a[1]; vert_a_z <= a[2];
        vert_b_x <= b[0]; vert_b_y <= b[1]; vert_b_z <= b[2];
        vert_c_x <= c[0]; vert_c_y <= c[1]; vert_c_z <= c[2];
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        nearest_q = {nearest_q, predict_nearest(p, a, b, c)};
    endtask

    function automatic vec3_t v3(int x, int y, int z);
        vec3_t r;
        r[0] = x; r[1] = y; r[2] = z;
        return r;
    endfunction

    function automatic vec3_t rand_vec(int kind);
        vec3_t r;
        for (int i = 0; i < 3; i++)
            case (kind)
                0: r[i] = $urandom;
                1: r[i] = ($urandom_range(0, 8) - 4) * Q1 + $urandom_range(0, Q1 - 1);
                2: r[i] = ($urandom_range(0, 4) - 2) * Q1;
                default: r[i] = $urandom_range(0, 1) ? 32'h7fffffff - $urandom_range(0, 3)
                                                     : 32'h80000000 + $urandom_range(0, 3);
            endcase
        return r;
    endfunction

    task automatic test_regions();
        vec3_t a, b, c;
        a = v3(0, 0, 0); b = v3(Q1, 0, 0); c = v3(0, Q1, 0);
        send_query(v3(-Q1, -Q1, 0), a, b, c);
        send_query(v3(2 * Q1, -Q1 / 2, 0), a, b, c);
        send_query(v3(-Q1 / 2, 2 * Q1, 0), a, b, c);
        send_query(v3(Q1 / 2, -Q1, Q1), a, b, c);
        send_query(v3(-Q1, Q1 / 3, -Q1), a, b, c);
        send_query(v3(Q1, Q1, 5), a, b, c);
        send_query(v3(Q1 / 4, Q1 / 4, Q1), a, b, c);
        send_query(v3(Q1 / 3, Q1 / 7, -3 * Q1), a, b, c);
    endtask

    task automatic test_degenerate();
        // zero-length edges, collinear and coincident vertices
        send_query(v3(Q1, Q1, 0), v3(0, 0, 0), v3(0, 0, 0), v3(2 * Q1, 0, 0));
        send_query(v3(Q1, Q1, 0), v3(0, 0, 0), v3(2 * Q1, 0, 0), v3(0, 0, 0));
        send_query(v3(Q1, Q1, 0), v3(0, 0, 0), v3(2 * Q1, 0, 0), v3(2 * Q1, 0, 0));
        send_query(v3(Q1, 3, 0), v3(0, 0, 0), v3(Q1, 0, 0), v3(2 * Q1, 0, 0));
        send_query(v3(Q1, Q1, Q1), v3(5, 5, 5), v3(5, 5, 5), v3(5, 5, 5));
        send_query(v3(5, 5, 5), v3(5, 5, 5), v3(5, 5, 5), v3(5, 5, 5));
    endtask

    task automatic test_extremes();
        int mx, mn;
        mx = 32'h7fffffff; mn = 32'h80000000;
        send_query(v3(mx, mx, mx), v3(mn, mn, mn), v3(mx, mn, mn), v3(mn, mx, mn));
        send_query(v3(mn, mn, mn), v3(mx, mx, mx), v3(mn, mx, mx), v3(mx, mn, mx));
        send_query(v3(0, 0, mx), v3(mn, mn, 0), v3(mx, mn, 0), v3(mn, mx, 0));
        send_query(v3(0, 0, 0), v3(mn, mn, mn), v3(mx, mx, mn), v3(mx, mn, mx));
        send_query(v3(mx, mn, 0), v3(mn, 0, mx), v3(0, mx, mn), v3(mx, mx, mx));
        send_query(v3(-1, -1, -1), v3(mn, mx, mn), v3(mx, mn, mx), v3(0, 0, 0));
    endtask

    task automatic test_random();
        int kind;
        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            if (n % 150 == 0)
            begin
                tx_no_gap = ($urandom_range(0, 2) == 0);
                rx_no_stall = ($urandom_range(0, 2) == 0);
            end
            kind = $urandom_range(0, 9);
            kind = (kind < 3) ? 0 : (kind < 7) ? 1 : (kind < 9) ? 2 : 3;
            send_query(rand_vec(kind), rand_vec(kind), rand_vec(kind), rand_vec(kind));
        end
        tx_no_gap = 1'b0;
        rx_no_stall = 1'b0;
    endtask

    task automatic test_backpressure();
        rx_hold = 300;
        tx_no_gap = 1'b1;
        for (int n = 0; n < 80; n++)
            send_query(rand_vec(1), rand_vec(1), rand_vec(1), rand_vec(1));
        tx_no_gap = 1'b0;
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_regions();
        test_degenerate();
        test_extremes();
        test_random();
        test_backpressure();
        in_valid <= 1'b0;
        while (nearest_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        $display("%0d results checked; regions A/B/C/AB/AC/BC/in: %0d %0d %0d %0d %0d %0d %0d",
                 results_seen, region_hits[0], region_hits[1], region_hits[2],
                 region_hits[3], region_hits[4], region_hits[5], region_hits[6]);
        $display("random and directed queries with input gaps, output stalls and a long hold-off");
        if (mismatches == 0)
            $display("TEST PASSED");
        else
        begin
            $display("%0d mismatches", mismatches);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
